FILE: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Widths, codes and reset values shared by the eject timer scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;

  localparam int TIME_W   = 18;
  localparam int TYPE_W   = 2;
  localparam int DELAY_W  = 16;
  localparam int TICK_W   = 10;
  localparam int PULSE_W  = 11;
  localparam int ENTRY_W  = TYPE_W + TIME_W;
  localparam int ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int FIRE_W   = $clog2(MAX_RESULTS + 1);
  localparam int ACC_W    = FIRE_W + PULSE_W;
  localparam int WIDE_W   = ((ACC_W + 1 > TIME_W + 1) ? ACC_W + 1 : TIME_W + 1) + 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PULSE_W;

  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  localparam logic [TICK_W-1:0]  TICK_PERIOD_RST  = TICK_W'(100);
  localparam logic [PULSE_W-1:0] PULSE_LENGTH_RST = PULSE_W'(500);

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = CFG_IDX_W'(1);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic EV_EJECT = 1'b0;
  localparam logic EV_DROP  = 1'b1;

endpackage

FILE: rtl/timed_eject_scheduler.sv
// Insert: written to the RAM in the same cycle it is accepted; a dropped insert passes
//   through S_DROP, which holds off the next request until its result is loaded.
// Tick: walks the entries (one RAM read per cycle while the output does not stall),
//   releases the final eject, then rewrites each remaining entry to apply the pulse
//   total when anything fired.
// Reset (rst, synchronous): table empty, registers at 100 ms and 500 ms.
// ----------------------------------------------------------------------------
// timed_eject_scheduler
// Ordered table of eject timers in one RAM; ticks age and fire them in order.
// ----------------------------------------------------------------------------
module timed_eject_scheduler
  import tes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // delay_ms[15:0], coin_kind[17:16], zeros
  input  logic                  s_tuser,   // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // eject_type[1:0], zeros
  output logic                  m_tuser,   // event_kind
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_FIX   = 3'd3;
  localparam logic [2:0] S_DROP  = 3'd4;

  logic [2:0]         state;
  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  rd_idx;
  logic [CNT_W-1:0]   wr_idx;
  logic [ACC_W-1:0]   acc;
  logic [FIRE_W-1:0]  fired;
  logic               pend_valid;
  logic [TYPE_W-1:0]  pend_type;
  logic [TYPE_W-1:0]  drop_type;
  logic [TICK_W-1:0]  tick_period;
  logic [PULSE_W-1:0] pulse_length;
  logic [TYPE_W-1:0]  out_type;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                     s_accept;
  logic                     in_op;
  logic [DELAY_W-1:0]       in_delay;
  logic [TYPE_W-1:0]        in_kind;
  logic                     out_can_load;
  logic signed [TIME_W-1:0] rd_time;
  logic [TYPE_W-1:0]        rd_type;
  logic signed [WIDE_W-1:0] rem_w;
  logic signed [WIDE_W-1:0] tick_w;
  logic signed [WIDE_W-1:0] acc_w;
  logic signed [WIDE_W-1:0] aged_w;
  logic signed [WIDE_W-1:0] fix_w;
  logic signed [TIME_W-1:0] aged_time;
  logic signed [TIME_W-1:0] fix_time;
  logic                     fire;
  logic                     stall;
  logic                     last_rd;

  tes_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready     = (state == S_IDLE);
  assign s_accept     = s_tvalid && s_tready;
  assign in_op        = s_tuser;
  assign in_delay     = s_tdata[DELAY_W-1:0];
  assign in_kind      = s_tdata[DELAY_W +: TYPE_W];
  assign cfg_ready    = 1'b1;
  assign out_can_load = !m_tvalid || m_tready;
  assign m_tdata      = OUT_DATA_W'(out_type);

  assign rd_time = ram_rdata[TIME_W-1:0];
  assign rd_type = ram_rdata[ENTRY_W-1:TIME_W];

  // Walk stores the entry aged by the tick only; the pulses of this tick are
  // held in acc, tested against on the way and applied in the fix pass.
  always_comb begin
    rem_w     = WIDE_W'(rd_time);
    tick_w    = WIDE_W'(tick_period);
    acc_w     = WIDE_W'(acc);
    aged_w    = rem_w - tick_w;
    fix_w     = rem_w - acc_w;
    aged_time = (aged_w < WIDE_W'(TIME_MIN)) ? TIME_MIN : aged_w[TIME_W-1:0];
    fix_time  = (fix_w < WIDE_W'(TIME_MIN)) ? TIME_MIN : fix_w[TIME_W-1:0];
    fire      = (WIDE_W'(aged_time) <= acc_w) && (fired < FIRE_W'(MAX_RESULTS));
    stall     = fire && pend_valid && !out_can_load;
    last_rd   = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          if (in_op == OP_INSERT && count < CNT_W'(SLOTS)) begin
            ram_we    = 1'b1;
            ram_waddr = count[ADDR_W-1:0];
            ram_wdata = {in_kind, TIME_W'(in_delay)};
          end else if (in_op == OP_TICK && count != '0) begin
            ram_re = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (!stall) begin
          if (!fire) begin
            ram_we    = 1'b1;
            ram_waddr = wr_idx[ADDR_W-1:0];
            ram_wdata = {rd_type, aged_time};
          end
          if (!last_rd) begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx + ADDR_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid && out_can_load && count != '0) begin
          ram_re = 1'b1;
        end
      end
      S_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx;
        ram_wdata = {rd_type, fix_time};
        if (!last_rd) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
      tick_period  <= TICK_PERIOD_RST;
      pulse_length <= PULSE_LENGTH_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TICK_PERIOD) begin
          tick_period <= cfg_data[TICK_W-1:0];
        end else if (cfg_index == CFG_PULSE_LENGTH) begin
          pulse_length <= cfg_data[PULSE_W-1:0];
        end
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_accept) begin
            if (in_op == OP_INSERT) begin
              if (count < CNT_W'(SLOTS)) begin
                count <= count + CNT_W'(1);
              end else begin
                drop_type <= in_kind;
                state     <= S_DROP;
              end
            end else if (count != '0) begin
              rd_idx     <= '0;
              wr_idx     <= '0;
              acc        <= '0;
              fired      <= '0;
              pend_valid <= 1'b0;
              state      <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (!stall) begin
            if (fire) begin
              // previous eject is now known not to be the final one
              if (pend_valid) begin
                m_tvalid <= 1'b1;
                m_tuser  <= EV_EJECT;
                out_type <= pend_type;
                m_tlast  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_type  <= rd_type;
              acc        <= acc + ACC_W'(pulse_length);
              fired      <= fired + FIRE_W'(1);
            end else begin
              wr_idx <= wr_idx + CNT_W'(1);
            end
            if (last_rd) begin
              count <= fire ? wr_idx : wr_idx + CNT_W'(1);
              state <= S_FLUSH;
            end else begin
              rd_idx <= rd_idx + ADDR_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_can_load) begin
            m_tvalid   <= 1'b1;
            m_tuser    <= EV_EJECT;
            out_type   <= pend_type;
            m_tlast    <= 1'b1;
            pend_valid <= 1'b0;
            rd_idx     <= '0;
            state      <= (count != '0) ? S_FIX : S_IDLE;
          end
        end
        S_FIX: begin
          if (last_rd) begin
            state <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + ADDR_W'(1);
          end
        end
        S_DROP: begin
          if (out_can_load) begin
            m_tvalid <= 1'b1;
            m_tuser  <= EV_DROP;
            out_type <= drop_type;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count beyond table size");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same entry in one cycle");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (wr_idx <= CNT_W'(rd_idx)))
    else $error("compaction pointer ahead of walk");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_WALK || state == S_FLUSH))
    else $error("held eject outside a tick walk");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP) |-> (count == CNT_W'(SLOTS)))
    else $error("insert dropped with room in table");
`endif

endmodule

FILE: rtl/tes_ram.sv
// ----------------------------------------------------------------------------
// tes_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
